/* rtl/tbc_pkg.sv */
// Shared types and constants for the translated block cache.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbc_pkg;

  localparam int ENTRIES    = 4096;
  localparam int PROBE_WAYS = 4;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int WAY_W      = $clog2(PROBE_WAYS + 1);
  localparam int SW_W       = IDX_W + 1;
  localparam int LIVE_W     = 13;

  localparam logic [31:0] MIX_C1 = 32'h85eb_ca6b;
  localparam logic [31:0] MIX_C2 = 32'hc2b2_ae35;

  typedef enum logic [2:0] {
    OP_BEGIN  = 3'd0,
    OP_ABSORB = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_INSERT = 3'd3,
    OP_INVAL  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] key;
    logic [63:0] handle;
    logic [63:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* rtl/tbc_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/tbc_mix.sv */
// Three-stage 32-bit hash finaliser, with a multiply in the second and third stages.
// Depends on tbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbc_mix (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] din,
  output logic             done,
  output logic [31:0]      dout
);

  logic [31:0] s0;
  logic [31:0] s1;
  logic [31:0] s2;
  logic [31:0] t1;
  logic [63:0] m1;
  logic [63:0] m2;
  logic [2:0]  vld;

  assign m1 = {32'd0, s0} * {32'd0, tbc_pkg::MIX_C1};
  assign t1 = s1 ^ (s1 >> 13);
  assign m2 = {32'd0, t1} * {32'd0, tbc_pkg::MIX_C2};

  always_ff @(posedge clk) begin
    s0 <= din ^ (din >> 16);
    s1 <= m1[31:0];
    s2 <= m2[31:0];
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], start};
    end
  end

  assign done = vld[2];
  assign dout = s2 ^ (s2 >> 16);

endmodule

`default_nettype wire

/* rtl/translated_block_cache.sv */
// Translated block cache: 4-way probed cache of code handles in one RAM.
// Begin/absorb run the three-stage hash unit; lookup/insert probe the ways in order, a lookup
// hit ending the probe early; invalidate and clear sweep every RAM entry.
// One item at a time: next beat taken the cycle after the result register loads.
// Reset: synchronous; a clearing pass over all ENTRIES (4096) RAM entries follows, no beats taken.
`timescale 1ns / 1ps
`default_nettype none

module translated_block_cache (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  operation,
  input  wire logic [31:0] pc,
  input  wire logic [31:0] instr_word,
  input  wire logic [63:0] code_handle,
  input  wire logic [31:0] range_start,
  input  wire logic [31:0] range_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             hit,
  output logic [63:0]      found_handle,
  output logic [63:0]      hit_total,
  output logic [63:0]      miss_total,
  output logic [12:0]      active_entries
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_MIX, S_PROBE, S_COMMIT, S_SWEEP, S_DONE
  } state_t;

  localparam int IW = tbc_pkg::IDX_W;

  state_t                        state;
  logic [2:0]                    op;
  logic [63:0]                   handle_in;
  logic [31:0]                   lo;
  logic [31:0]                   hi;
  logic [31:0]                   run_key;
  logic [31:0]                   held_pc;
  logic [63:0]                   tick;
  logic [63:0]                   hits;
  logic [63:0]                   misses;
  logic [tbc_pkg::LIVE_W-1:0]    live;
  logic [tbc_pkg::WAY_W-1:0]     rd_way;
  logic                          pr_vld;
  logic                          pr_first;
  logic                          pr_last;
  logic [IW-1:0]                 pr_q;
  logic                          placed;
  logic                          found;
  logic [IW-1:0]                 pick;
  logic [63:0]                   oldest;
  tbc_pkg::entry_t               hit_ent;
  logic [tbc_pkg::SW_W-1:0]      sw_cnt;
  logic                          sw_vld;
  logic [IW-1:0]                 sw_q;

  logic                          mix_start;
  logic [31:0]                   mix_din;
  logic                          mix_done;
  logic [31:0]                   mix_dout;

  logic                          we;
  logic [IW-1:0]                 waddr;
  tbc_pkg::entry_t               wdata;
  logic [IW-1:0]                 raddr;
  tbc_pkg::entry_t               ent;
  logic [IW-1:0]                 probe_addr;
  logic                          match;
  logic                          in_range;
  logic                          take;
  logic                          out_free;

  tbc_ram #(
    .WIDTH (tbc_pkg::ENTRY_W),
    .DEPTH (tbc_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ent)
  );

  tbc_mix u_mix (
    .clk   (clk),
    .rst   (rst),
    .start (mix_start),
    .din   (mix_din),
    .done  (mix_done),
    .dout  (mix_dout)
  );

  assign in_stall   = (state != S_IDLE);
  assign take       = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign probe_addr = run_key[IW-1:0] + IW'(rd_way);
  assign match      = (ent.handle != 64'd0) && (ent.pc == held_pc) && (ent.key == run_key);
  assign in_range   = (ent.pc >= lo) && (ent.pc <= hi);
  assign mix_start  = take && (operation == tbc_pkg::OP_BEGIN ||
                               operation == tbc_pkg::OP_ABSORB);
  assign mix_din    = (operation == tbc_pkg::OP_BEGIN) ? pc : (run_key ^ instr_word);
  assign raddr      = (state == S_PROBE) ? probe_addr : sw_cnt[IW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = sw_cnt[IW-1:0];
    wdata = '0;
    if (state == S_INIT || (state == S_SWEEP && op == tbc_pkg::OP_CLEAR)) begin
      we = 1'b1;
    end else if (state == S_SWEEP) begin
      we          = sw_vld && in_range;
      waddr       = sw_q;
      wdata.stamp = ent.stamp;
    end else if (state == S_COMMIT) begin
      waddr = pick;
      if (op == tbc_pkg::OP_LOOKUP) begin
        we          = found;
        wdata       = hit_ent;
        wdata.stamp = tick;
      end else begin
        we           = 1'b1;
        wdata.pc     = held_pc;
        wdata.key    = run_key;
        wdata.handle = handle_in;
        wdata.stamp  = tick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      run_key   <= '0;
      held_pc   <= '0;
      tick      <= '0;
      hits      <= '0;
      misses    <= '0;
      live      <= '0;
      sw_cnt    <= '0;
      sw_vld    <= 1'b0;
      pr_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          sw_cnt <= sw_cnt + 1'b1;
          if (sw_cnt == tbc_pkg::SW_W'(tbc_pkg::ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            op        <= operation;
            handle_in <= code_handle;
            lo        <= range_start;
            hi        <= range_end;
            found     <= 1'b0;
            rd_way    <= '0;
            pr_vld    <= 1'b0;
            sw_cnt    <= '0;
            sw_vld    <= 1'b0;
            case (operation)
              tbc_pkg::OP_BEGIN: begin
                held_pc <= pc;
                state   <= S_MIX;
              end
              tbc_pkg::OP_ABSORB: state <= S_MIX;
              tbc_pkg::OP_LOOKUP, tbc_pkg::OP_INSERT: state <= S_PROBE;
              tbc_pkg::OP_INVAL: state <= S_SWEEP;
              tbc_pkg::OP_CLEAR: begin
                hits   <= '0;
                misses <= '0;
                live   <= '0;
                state  <= S_SWEEP;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_MIX: begin
          if (mix_done) begin
            run_key <= mix_dout;
            state   <= S_DONE;
          end
        end
        S_PROBE: begin
          pr_vld <= 1'b0;
          if (rd_way < tbc_pkg::WAY_W'(tbc_pkg::PROBE_WAYS)) begin
            rd_way   <= rd_way + 1'b1;
            pr_vld   <= 1'b1;
            pr_q     <= probe_addr;
            pr_first <= (rd_way == '0);
            pr_last  <= (rd_way == tbc_pkg::WAY_W'(tbc_pkg::PROBE_WAYS - 1));
          end
          if (pr_vld) begin
            if (op == tbc_pkg::OP_LOOKUP) begin
              if (match) begin
                found   <= 1'b1;
                pick    <= pr_q;
                hit_ent <= ent;
                state   <= S_COMMIT;
              end else if (pr_last) begin
                state <= S_COMMIT;
              end
            end else begin
              if (pr_first) begin
                pick   <= pr_q;
                oldest <= ent.stamp;
                placed <= (ent.handle == 64'd0);
              end else if (!placed) begin
                if (ent.handle == 64'd0) begin
                  placed <= 1'b1;
                  pick   <= pr_q;
                end else if (ent.stamp < oldest) begin
                  oldest <= ent.stamp;
                  pick   <= pr_q;
                end
              end
              if (pr_last) begin
                state <= S_COMMIT;
              end
            end
          end
        end
        S_COMMIT: begin
          pr_vld <= 1'b0;
          if (op == tbc_pkg::OP_LOOKUP) begin
            if (found) begin
              tick <= tick + 64'd1;
              hits <= hits + 64'd1;
            end else begin
              misses <= misses + 64'd1;
            end
          end else begin
            tick <= tick + 64'd1;
            live <= live - tbc_pkg::LIVE_W'(!placed)
                         + tbc_pkg::LIVE_W'(handle_in != 64'd0);
          end
          state <= S_DONE;
        end
        S_SWEEP: begin
          if (op == tbc_pkg::OP_CLEAR) begin
            sw_cnt <= sw_cnt + 1'b1;
            if (sw_cnt == tbc_pkg::SW_W'(tbc_pkg::ENTRIES - 1)) begin
              state <= S_DONE;
            end
          end else begin
            sw_vld <= !sw_cnt[IW];
            sw_q   <= sw_cnt[IW-1:0];
            if (!sw_cnt[IW]) begin
              sw_cnt <= sw_cnt + 1'b1;
            end
            if (sw_vld) begin
              if (in_range && ent.handle != 64'd0) begin
                live <= live - 1'b1;
              end
              if (sw_q == IW'(tbc_pkg::ENTRIES - 1)) begin
                state <= S_DONE;
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            hit            <= found && (op == tbc_pkg::OP_LOOKUP);
            found_handle   <= (found && op == tbc_pkg::OP_LOOKUP) ? hit_ent.handle : 64'd0;
            hit_total      <= hits;
            miss_total     <= misses;
            active_entries <= live;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hit_handle: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> found_handle != 64'd0)
    else $error("hit beat with empty handle");

  a_miss_handle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> found_handle == 64'd0)
    else $error("handle on non-hit beat");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE || state == S_DONE || state == S_MIX |-> !we)
    else $error("RAM write outside an operation");

  a_commit_from_probe: assert property (@(posedge clk) disable iff (rst)
    state == S_COMMIT |-> $past(state) == S_PROBE)
    else $error("commit not preceded by probe");
`endif

endmodule

`default_nettype wire
